// File: rtl/core/wgc_pkg.sv
`timescale 1ns / 1ps

package wgc_pkg;

    localparam int ITER_W    = 5;
    localparam int VEC_W     = 40;
    localparam int ANG_W     = 34;
    localparam int YAW_W     = ANG_W - 17;
    localparam int ERR_W     = 18;
    localparam int MAG_W     = 36;
    localparam int MAG_HALF  = MAG_W / 2;
    localparam int MACC_W    = 60;
    localparam int DIST_W    = 34;
    localparam int DIST_HALF = DIST_W / 2;
    localparam int LACC_W    = 50;
    localparam int APROD_W   = 35;

    localparam logic signed [VEC_W-1:0]  T1_BIAS     = VEC_W'(268435456);
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = ANG_W'(1686629713);
    localparam logic signed [ANG_W-1:0]  Z_ROUND     = ANG_W'(65536);
    localparam logic [23:0]              INV_K_Q24   = 24'd10187942;
    localparam logic [MACC_W-1:0]        DIST_ROUND  = MACC_W'(33554432);
    localparam logic [LACC_W-1:0]        LIN_ROUND   = LACC_W'(32768);
    localparam logic signed [APROD_W-1:0] ANG_ROUND  = APROD_W'(65536);
    localparam logic signed [ERR_W-1:0]  PI_Q13      = ERR_W'(25736);
    localparam logic signed [ERR_W-1:0]  TWO_PI_Q13  = ERR_W'(51472);

    typedef enum logic [1:0] {
        REG_ANGLE_GAIN  = 2'd0,
        REG_LINEAR_GAIN = 2'd1,
        REG_ANGLE_TOL   = 2'd2,
        REG_DIST_TOL    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] angle_gain;
        logic [15:0] linear_gain;
        logic [14:0] angle_tolerance;
        logic [15:0] distance_tolerance;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GOAL,
        OP_MUL,
        OP_LOAD_YAW,
        OP_LOAD_BRG,
        OP_ITER,
        OP_SAVE_YAW,
        OP_SAVE_BRG,
        OP_MAG,
        OP_EVAL,
        OP_CMD,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [1:0]        step;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic goal_received;
    } dp_stat_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (i)
                5'd0:    v = ANG_W'(843314857);
                5'd1:    v = ANG_W'(497837829);
                5'd2:    v = ANG_W'(263043837);
                5'd3:    v = ANG_W'(133525159);
                5'd4:    v = ANG_W'(67021687);
                5'd5:    v = ANG_W'(33543516);
                5'd6:    v = ANG_W'(16775851);
                5'd7:    v = ANG_W'(8388437);
                5'd8:    v = ANG_W'(4194283);
                5'd9:    v = ANG_W'(2097149);
                5'd10:   v = ANG_W'(1048576);
                5'd11:   v = ANG_W'(524288);
                5'd12:   v = ANG_W'(262144);
                5'd13:   v = ANG_W'(131072);
                5'd14:   v = ANG_W'(65536);
                5'd15:   v = ANG_W'(32768);
                5'd16:   v = ANG_W'(16384);
                5'd17:   v = ANG_W'(8192);
                5'd18:   v = ANG_W'(4096);
                5'd19:   v = ANG_W'(2048);
                5'd20:   v = ANG_W'(1024);
                5'd21:   v = ANG_W'(512);
                5'd22:   v = ANG_W'(256);
                5'd23:   v = ANG_W'(128);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/core/wgc_if.sv
`timescale 1ns / 1ps

interface wgc_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] goal_heading;

    modport source (output valid, mode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    goal_heading, input ready);
    modport sink (input valid, mode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  goal_heading, output ready);
endinterface

interface wgc_out_if;
    logic               valid;
    logic               ready;
    logic [30:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               waypoint_active;
    logic               position_ok;
    logic               angle_ok;

    modport source (output valid, linear_cmd, angular_cmd, waypoint_active, position_ok,
                    angle_ok, input ready);
    modport sink (input valid, linear_cmd, angular_cmd, waypoint_active, position_ok,
                  angle_ok, output ready);
endinterface

// File: rtl/core/wgc_ctrl.sv
`timescale 1ns / 1ps

module wgc_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  wgc_pkg::dp_stat_t  stat,
    output wgc_pkg::dp_cmd_t   cmd
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL,
        S_YLOAD,
        S_YITER,
        S_YSAVE,
        S_BLOAD,
        S_BITER,
        S_BSAVE,
        S_MAG,
        S_EVAL,
        S_CMD,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] iter_reg;
    logic [1:0]       step_reg;
    logic             out_valid_reg;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op   = wgc_pkg::OP_NONE;
        cmd.step = step_reg;
        cmd.iter = wgc_pkg::ITER_W'(iter_reg);
        unique case (state_reg)
            S_IDLE:   cmd.op = in_valid ? wgc_pkg::OP_LOAD : wgc_pkg::OP_NONE;
            S_DECIDE: cmd.op = stat.mode ? wgc_pkg::OP_NONE : wgc_pkg::OP_GOAL;
            S_MUL:    cmd.op = wgc_pkg::OP_MUL;
            S_YLOAD:  cmd.op = wgc_pkg::OP_LOAD_YAW;
            S_YITER:  cmd.op = wgc_pkg::OP_ITER;
            S_YSAVE:  cmd.op = wgc_pkg::OP_SAVE_YAW;
            S_BLOAD:  cmd.op = wgc_pkg::OP_LOAD_BRG;
            S_BITER:  cmd.op = wgc_pkg::OP_ITER;
            S_BSAVE:  cmd.op = wgc_pkg::OP_SAVE_BRG;
            S_MAG:    cmd.op = wgc_pkg::OP_MAG;
            S_EVAL:   cmd.op = wgc_pkg::OP_EVAL;
            S_CMD:    cmd.op = wgc_pkg::OP_CMD;
            S_DONE:   cmd.op = slot_free ? wgc_pkg::OP_RESULT : wgc_pkg::OP_NONE;
            default:  cmd.op = wgc_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    step_reg <= '0;
                    if (stat.mode && stat.goal_received)
                        state_reg <= S_MUL;
                    else
                        state_reg <= S_IDLE;
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_reg <= S_YLOAD;
                end
                S_YLOAD:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_YITER;
                end
                S_YITER:
                begin
                    iter_reg <= iter_reg + CNT_W'(1);
                    if (iter_reg == LAST_ITER)
                        state_reg <= S_YSAVE;
                end
                S_YSAVE:  state_reg <= S_BLOAD;
                S_BLOAD:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_BITER;
                end
                S_BITER:
                begin
                    iter_reg <= iter_reg + CNT_W'(1);
                    if (iter_reg == LAST_ITER)
                        state_reg <= S_BSAVE;
                end
                S_BSAVE:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd1)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    step_reg  <= '0;
                    state_reg <= S_CMD;
                end
                S_CMD:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd1)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/wgc_dp.sv
`timescale 1ns / 1ps

module wgc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  wgc_pkg::dp_cmd_t   cmd,
    output wgc_pkg::dp_stat_t  stat,
    input  wgc_pkg::cfg_t      cfg,
    input  logic               in_mode,
    input  logic signed [31:0] in_pos_x,
    input  logic signed [31:0] in_pos_y,
    input  logic signed [15:0] in_quat_x,
    input  logic signed [15:0] in_quat_y,
    input  logic signed [15:0] in_quat_z,
    input  logic signed [15:0] in_quat_w,
    input  logic signed [15:0] in_goal_heading,
    output logic [30:0]        linear_cmd,
    output logic signed [15:0] angular_cmd,
    output logic               waypoint_active,
    output logic               position_ok,
    output logic               angle_ok
);

    localparam int VEC_W  = wgc_pkg::VEC_W;
    localparam int ANG_W  = wgc_pkg::ANG_W;
    localparam int YAW_W  = wgc_pkg::YAW_W;
    localparam int ERR_W  = wgc_pkg::ERR_W;
    localparam int MAG_W  = wgc_pkg::MAG_W;
    localparam int MH     = wgc_pkg::MAG_HALF;
    localparam int MACC_W = wgc_pkg::MACC_W;
    localparam int DIST_W = wgc_pkg::DIST_W;
    localparam int DH     = wgc_pkg::DIST_HALF;
    localparam int LACC_W = wgc_pkg::LACC_W;
    localparam int AP_W   = wgc_pkg::APROD_W;

    // latched item
    logic               mode_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg, hd_reg;

    // controller state
    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic signed [15:0] goal_heading_reg;
    logic               armed_reg, goal_received_reg;

    // working registers
    logic signed [32:0]       acc0_reg, acc1_reg;
    logic signed [VEC_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic                     zero_reg;
    logic signed [YAW_W-1:0]  yaw_reg, brg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [MACC_W-1:0]        macc_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic signed [ERR_W-1:0]  chosen_reg;
    logic                     loc_reg, angm_reg, fin_ok_reg;
    logic [LACC_W-1:0]        lacc_reg;
    logic signed [AP_W-1:0]   aprod_reg;

    // output payload
    logic [30:0]        lin_out_reg;
    logic signed [15:0] ang_out_reg;
    logic               active_out_reg, locm_out_reg, angm_out_reg;

    assign stat.mode          = mode_reg;
    assign stat.goal_received = goal_received_reg;
    assign linear_cmd         = lin_out_reg;
    assign angular_cmd        = ang_out_reg;
    assign waypoint_active    = active_out_reg;
    assign position_ok        = locm_out_reg;
    assign angle_ok           = angm_out_reg;

    // quaternion products, one per step
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] mul_p;

    always_comb
    begin
        unique case (cmd.step)
            2'd0:    begin mul_a = qw_reg; mul_b = qz_reg; end
            2'd1:    begin mul_a = qx_reg; mul_b = qy_reg; end
            2'd2:    begin mul_a = qy_reg; mul_b = qy_reg; end
            default: begin mul_a = qz_reg; mul_b = qz_reg; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // vector load with quadrant pre-rotation
    logic signed [32:0]      dx, dy;
    logic signed [VEC_W-1:0] ld_x, ld_y, pr_x, pr_y;
    logic signed [ANG_W-1:0] pr_z;

    always_comb
    begin
        dx = 33'(goal_x_reg) - 33'(px_reg);
        dy = 33'(goal_y_reg) - 33'(py_reg);
        if (cmd.op == wgc_pkg::OP_LOAD_BRG)
        begin
            ld_x = VEC_W'(dx) <<< 2;
            ld_y = VEC_W'(dy) <<< 2;
        end
        else
        begin
            ld_x = wgc_pkg::T1_BIAS - (VEC_W'(acc1_reg) <<< 1);
            ld_y = VEC_W'(acc0_reg) <<< 1;
        end
        pr_x = ld_x;
        pr_y = ld_y;
        pr_z = '0;
        if (ld_x < 0)
        begin
            if (ld_y >= 0)
            begin
                pr_x = ld_y;
                pr_y = -ld_x;
                pr_z = wgc_pkg::HALF_PI_Q30;
            end
            else
            begin
                pr_x = -ld_y;
                pr_y = ld_x;
                pr_z = -wgc_pkg::HALF_PI_Q30;
            end
        end
    end

    // one cordic micro-rotation
    logic signed [VEC_W-1:0] sh_x, sh_y;
    logic signed [ANG_W-1:0] at;
    logic signed [ANG_W-1:0] z_rnd;
    logic signed [YAW_W-1:0] z_q13;

    always_comb
    begin
        sh_x  = x_reg >>> cmd.iter;
        sh_y  = y_reg >>> cmd.iter;
        at    = wgc_pkg::atan_q30(cmd.iter);
        z_rnd = z_reg + wgc_pkg::Z_ROUND;
        z_q13 = zero_reg ? '0 : z_rnd[ANG_W-1:17];
    end

    // magnitude scaling, command products
    logic [MH+23:0]          mprod;
    logic [MACC_W-1:0]       dist_sum;
    logic [DH+15:0]          lprod;
    logic signed [AP_W-1:0]  aprod;

    always_comb
    begin
        mprod    = (cmd.step[0] ? mag_reg[MAG_W-1:MH] : mag_reg[MH-1:0]) * wgc_pkg::INV_K_Q24;
        dist_sum = macc_reg + wgc_pkg::DIST_ROUND;
        lprod    = (cmd.step[0] ? dist_reg[DIST_W-1:DH] : dist_reg[DH-1:0]) * cfg.linear_gain;
        aprod    = $signed({1'b0, cfg.angle_gain}) * chosen_reg;
    end

    // angle errors and tests
    logic signed [ERR_W-1:0] err0, err1, err2, fin, chosen, achosen, afin;
    logic [DIST_W-1:0]       dist_v;
    logic                    loc_v;

    always_comb
    begin
        dist_v  = dist_sum[MACC_W-1:26];
        err0    = ERR_W'(brg_reg) - ERR_W'(yaw_reg);
        err1    = (err0 > wgc_pkg::PI_Q13) ? err0 - wgc_pkg::TWO_PI_Q13 : err0;
        err2    = (err1 < -wgc_pkg::PI_Q13) ? err1 + wgc_pkg::TWO_PI_Q13 : err1;
        fin     = ERR_W'(goal_heading_reg) - ERR_W'(yaw_reg);
        loc_v   = dist_v < DIST_W'(cfg.distance_tolerance);
        chosen  = loc_v ? fin : err2;
        achosen = (chosen < 0) ? -chosen : chosen;
        afin    = (fin < 0) ? -fin : fin;
    end

    // result formation
    logic [LACC_W-1:0]      lin_sum;
    logic [33:0]            lin_q;
    logic [30:0]            lin_sat;
    logic signed [AP_W-1:0] ang_sum;
    logic signed [17:0]     ang_q;
    logic signed [15:0]     ang_sat;
    logic                   do_turn, do_fwd, loc_final;

    always_comb
    begin
        lin_sum = lacc_reg + wgc_pkg::LIN_ROUND;
        lin_q   = lin_sum[49:16];
        lin_sat = (|lin_q[33:31]) ? 31'h7FFF_FFFF : lin_q[30:0];
        ang_sum = aprod_reg + wgc_pkg::ANG_ROUND;
        ang_q   = ang_sum[AP_W-1:17];
        if (ang_q > 18'sd32767)
            ang_sat = 16'sh7FFF;
        else if (ang_q < -18'sd32768)
            ang_sat = 16'sh8000;
        else
            ang_sat = ang_q[15:0];
        do_turn   = armed_reg && !angm_reg;
        do_fwd    = armed_reg && angm_reg && !loc_reg;
        loc_final = loc_reg || !(do_turn || do_fwd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            goal_heading_reg  <= '0;
            armed_reg         <= 1'b0;
            goal_received_reg <= 1'b0;
            mode_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.op == wgc_pkg::OP_LOAD)
                mode_reg <= in_mode;
            if (cmd.op == wgc_pkg::OP_GOAL)
            begin
                goal_x_reg        <= px_reg;
                goal_y_reg        <= py_reg;
                goal_heading_reg  <= hd_reg;
                armed_reg         <= 1'b1;
                goal_received_reg <= 1'b1;
            end
            if (cmd.op == wgc_pkg::OP_RESULT && loc_final && fin_ok_reg)
                armed_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            wgc_pkg::OP_LOAD:
            begin
                px_reg <= in_pos_x;
                py_reg <= in_pos_y;
                qx_reg <= in_quat_x;
                qy_reg <= in_quat_y;
                qz_reg <= in_quat_z;
                qw_reg <= in_quat_w;
                hd_reg <= in_goal_heading;
            end
            wgc_pkg::OP_MUL:
            begin
                unique case (cmd.step)
                    2'd0:    acc0_reg <= 33'(mul_p);
                    2'd1:    acc0_reg <= acc0_reg + 33'(mul_p);
                    2'd2:    acc1_reg <= 33'(mul_p);
                    default: acc1_reg <= acc1_reg + 33'(mul_p);
                endcase
            end
            wgc_pkg::OP_LOAD_YAW, wgc_pkg::OP_LOAD_BRG:
            begin
                x_reg    <= pr_x;
                y_reg    <= pr_y;
                z_reg    <= pr_z;
                zero_reg <= (ld_x == 0) && (ld_y == 0);
            end
            wgc_pkg::OP_ITER:
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + sh_y;
                    y_reg <= y_reg - sh_x;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - sh_y;
                    y_reg <= y_reg + sh_x;
                    z_reg <= z_reg - at;
                end
            end
            wgc_pkg::OP_SAVE_YAW:
                yaw_reg <= z_q13;
            wgc_pkg::OP_SAVE_BRG:
            begin
                brg_reg <= z_q13;
                mag_reg <= zero_reg ? '0 : x_reg[MAG_W-1:0];
            end
            wgc_pkg::OP_MAG:
            begin
                if (cmd.step[0])
                    macc_reg <= macc_reg + (MACC_W'(mprod) << MH);
                else
                    macc_reg <= MACC_W'(mprod);
            end
            wgc_pkg::OP_EVAL:
            begin
                dist_reg   <= dist_v;
                loc_reg    <= loc_v;
                chosen_reg <= chosen;
                angm_reg   <= achosen < ERR_W'(cfg.angle_tolerance);
                fin_ok_reg <= afin < ERR_W'(cfg.angle_tolerance);
            end
            wgc_pkg::OP_CMD:
            begin
                if (cmd.step[0])
                    lacc_reg <= lacc_reg + (LACC_W'(lprod) << DH);
                else
                begin
                    lacc_reg  <= LACC_W'(lprod);
                    aprod_reg <= aprod;
                end
            end
            wgc_pkg::OP_RESULT:
            begin
                lin_out_reg    <= do_fwd ? lin_sat : '0;
                ang_out_reg    <= do_turn ? ang_sat : '0;
                locm_out_reg   <= loc_final;
                angm_out_reg   <= angm_reg;
                active_out_reg <= armed_reg && !(loc_final && fin_ok_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/core/waypoint_go_to_goal_controller.sv
`timescale 1ns / 1ps

// Go-to-goal controller for a differential-drive robot. A goal beat (mode 0) stores the
// target position and final heading and arms the waypoint; it gives no result. A pose
// beat (mode 1) gives one result beat once a goal has been received: yaw from the
// quaternion and distance/bearing to the goal come from one shared vectoring CORDIC,
// used twice. A finished result waits in the output register while the next beat is
// taken. Gains and tolerances sit in an APB register file at byte offsets 0, 4, 8, 12
// and should be written only while the block is idle.
module waypoint_go_to_goal_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    wgc_in_if.sink      in_ch,
    wgc_out_if.source   out_ch
);

    wgc_pkg::cfg_t      cfg_reg;
    wgc_pkg::reg_idx_t  reg_idx;
    wgc_pkg::dp_cmd_t   cmd;
    wgc_pkg::dp_stat_t  stat;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = wgc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_gain         <= 16'd42598;
            cfg_reg.linear_gain        <= 16'd62259;
            cfg_reg.angle_tolerance    <= 15'd737;
            cfg_reg.distance_tolerance <= 16'd7;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                wgc_pkg::REG_ANGLE_GAIN:  cfg_reg.angle_gain         <= pwdata[15:0];
                wgc_pkg::REG_LINEAR_GAIN: cfg_reg.linear_gain        <= pwdata[15:0];
                wgc_pkg::REG_ANGLE_TOL:   cfg_reg.angle_tolerance    <= pwdata[14:0];
                default:                  cfg_reg.distance_tolerance <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            wgc_pkg::REG_ANGLE_GAIN:  prdata = 32'(cfg_reg.angle_gain);
            wgc_pkg::REG_LINEAR_GAIN: prdata = 32'(cfg_reg.linear_gain);
            wgc_pkg::REG_ANGLE_TOL:   prdata = 32'(cfg_reg.angle_tolerance);
            default:                  prdata = 32'(cfg_reg.distance_tolerance);
        endcase
    end

    wgc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wgc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg             (cfg_reg),
        .in_mode         (in_ch.mode),
        .in_pos_x        (in_ch.pos_x),
        .in_pos_y        (in_ch.pos_y),
        .in_quat_x       (in_ch.quat_x),
        .in_quat_y       (in_ch.quat_y),
        .in_quat_z       (in_ch.quat_z),
        .in_quat_w       (in_ch.quat_w),
        .in_goal_heading (in_ch.goal_heading),
        .linear_cmd      (out_ch.linear_cmd),
        .angular_cmd     (out_ch.angular_cmd),
        .waypoint_active (out_ch.waypoint_active),
        .position_ok     (out_ch.position_ok),
        .angle_ok        (out_ch.angle_ok)
    );

`ifndef SYNTHESIS
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken again right after a beat");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(!in_ch.ready))
        else $error("result appeared without a pose being worked");

    a_gain_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && reg_idx == wgc_pkg::REG_ANGLE_GAIN)
        |=> cfg_reg.angle_gain == $past(pwdata[15:0]))
        else $error("angle gain write lost");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit        mode;
        bit [31:0] px;
        bit [31:0] py;
        bit [15:0] qx;
        bit [15:0] qy;
        bit [15:0] qz;
        bit [15:0] qw;
        bit [15:0] hdg;
    } pose_item_t;

    typedef struct {
        bit [30:0] lin;
        bit [15:0] ang;
        bit        active;
        bit        loc;
        bit        angm;
    } cmd_t;

    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    wgc_in_if in_ch ();
    wgc_out_if out_ch ();

    waypoint_go_to_goal_controller dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // predictor state
    longint unsigned gain_ang, gain_lin, tol_ang, tol_dist;
    int goal_x, goal_y, goal_hdg;
    bit armed, have_goal;

    pose_item_t pending_q[$];
    cmd_t expected_q[$];
    int errors;
    int cycles;
    bit quiet;
    int hold_cnt;
    bit sender_pause;
    bit taken;
    int idle_burst;
    int ready_burst;
    int feed_target;

    longint atan_q30_tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vec_angle(longint x0, longint y0, output longint mag);
        longint x, y, z, t;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 1686629713;
            end
            else
            begin
                x = -y;
                y = t;
                z = -1686629713;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            t = x;
            if (y >= 0)
            begin
                x += floor_shift(y, i);
                y -= floor_shift(t, i);
                z += atan_q30_tab[i];
            end
            else
            begin
                x -= floor_shift(y, i);
                y += floor_shift(t, i);
                z -= atan_q30_tab[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint to_q13(longint z);
        return (z + 65536) >>> 17;
    endfunction

    task automatic predict_step(input pose_item_t it);
        longint qx, qy, qz, qw, t0, t1, dx, dy, mag, distance, lin, ang;
        longint yaw, bearing, err, fin, chosen, achosen, afin;
        bit loc_met, ang_met;
        cmd_t c;
        lin = 0;
        ang = 0;
        if (!it.mode)
        begin
            goal_x = $signed(it.px);
            goal_y = $signed(it.py);
            goal_hdg = $signed(it.hdg);
            armed = 1;
            have_goal = 1;
            return;
        end
        if (!have_goal)
            return;
        qx = $signed(it.qx);
        qy = $signed(it.qy);
        qz = $signed(it.qz);
        qw = $signed(it.qw);
        t0 = 2 * (qw * qz + qx * qy);
        t1 = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        yaw = to_q13(vec_angle(t1, t0, mag));
        dx = longint'(goal_x) - longint'($signed(it.px));
        dy = longint'(goal_y) - longint'($signed(it.py));
        bearing = to_q13(vec_angle(dx * 4, dy * 4, mag));
        distance = (mag * 10187942 + (64'sd1 <<< 25)) >>> 26;
        err = bearing - yaw;
        if (err > 25736)
            err -= 51472;
        if (err < -25736)
            err += 51472;
        fin = goal_hdg - yaw;
        loc_met = distance < longint'(tol_dist);
        chosen = loc_met ? fin : err;
        achosen = chosen < 0 ? -chosen : chosen;
        ang_met = achosen < longint'(tol_ang);
        if (armed && !ang_met)
        begin
            ang = (longint'(gain_ang) * chosen + 65536) >>> 17;
            if (ang > 32767)
                ang = 32767;
            if (ang < -32768)
                ang = -32768;
        end
        else if (armed && !loc_met)
        begin
            lin = (longint'(gain_lin) * distance + 32768) >>> 16;
            if (lin > 2147483647)
                lin = 2147483647;
        end
        else
            loc_met = 1;
        afin = fin < 0 ? -fin : fin;
        if (loc_met && afin < longint'(tol_ang))
            armed = 0;
        c.lin = lin[30:0];
        c.ang = ang[15:0];
        c.active = armed;
        c.loc = loc_met;
        c.angm = ang_met;
        expected_q.push_back(c);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || taken))
        begin
            taken = 1'b0;
            if (idle_burst > 0)
            begin
                idle_burst--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_q.size() > 0 && !sender_pause)
            begin
                in_ch.valid <= 1'b1;
                in_ch.mode <= pending_q[0].mode;
                in_ch.pos_x <= pending_q[0].px;
                in_ch.pos_y <= pending_q[0].py;
                in_ch.quat_x <= pending_q[0].qx;
                in_ch.quat_y <= pending_q[0].qy;
                in_ch.quat_z <= pending_q[0].qz;
                in_ch.quat_w <= pending_q[0].qw;
                in_ch.goal_heading <= pending_q[0].hdg;
                if (!quiet && $urandom_range(0, 9) == 0)
                    idle_burst = $urandom_range(1, 18);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // sender-side acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_step(pending_q.pop_front());
            taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end
        else if (ready_burst > 0)
        begin
            ready_burst--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 19) == 0)
                ready_burst = $urandom_range(1, 18);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cmd_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.linear_cmd !== e.lin)
                    report_mismatch("linear_cmd", out_ch.linear_cmd, e.lin);
                if (out_ch.angular_cmd !== e.ang)
                    report_mismatch("angular_cmd", $signed(out_ch.angular_cmd),
                        $signed(e.ang));
                if (out_ch.waypoint_active !== e.active)
                    report_mismatch("waypoint_active", out_ch.waypoint_active, e.active);
                if (out_ch.position_ok !== e.loc)
                    report_mismatch("position_ok", out_ch.position_ok, e.loc);
                if (out_ch.angle_ok !== e.angm)
                    report_mismatch("angle_ok", out_ch.angle_ok, e.angm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic cfg_write(input wgc_pkg::reg_idx_t idx, input longint unsigned v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wgc_pkg::REG_ANGLE_GAIN: gain_ang = v & 16'hFFFF;
            wgc_pkg::REG_LINEAR_GAIN: gain_lin = v & 16'hFFFF;
            wgc_pkg::REG_ANGLE_TOL: tol_ang = v & 15'h7FFF;
            default: tol_dist = v & 16'hFFFF;
        endcase
    endtask

    task automatic push_item(input bit m, input bit [31:0] x, input bit [31:0] y,
        input bit [15:0] qx, input bit [15:0] qy, input bit [15:0] qz, input bit [15:0] qw,
        input bit [15:0] h);
        pose_item_t it;
        it.mode = m;
        it.px = x;
        it.py = y;
        it.qx = qx;
        it.qy = qy;
        it.qz = qz;
        it.qw = qw;
        it.hdg = h;
        pending_q.push_back(it);
        feed_target++;
    endtask

    function automatic bit [15:0] rand_quat();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic bit [15:0] rand_hdg();
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    function automatic bit [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 24'sh800000);
        endcase
    endfunction

    // a goal beat, then random poses, some near the goal so that arrival and disarm get exercised
    task automatic random_episode();
        bit [31:0] gx, gy;
        bit [15:0] gh, c, s;
        int n;
        gx = rand_pos();
        gy = rand_pos();
        gh = rand_hdg();
        push_item(1'b0, gx, gy, rand_quat(), rand_quat(), rand_quat(), rand_quat(), gh);
        n = $urandom_range(2, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                c = 16'($urandom_range(0, 16384));
                s = rand_quat();
                push_item(1'b1, gx + 32'($signed($urandom_range(0, 8)) - 4), gy, 16'd0,
                    16'd0, s, c, rand_hdg());
            end
            else
                push_item(1'b1, rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                    rand_quat(), rand_quat(), rand_hdg());
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || expected_q.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        in_ch.quat_w = '0;
        in_ch.goal_heading = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        cycles = 0;
        quiet = 0;
        hold_cnt = 0;
        sender_pause = 0;
        taken = 0;
        idle_burst = 0;
        ready_burst = 0;
        gain_ang = 42598;
        gain_lin = 62259;
        tol_ang = 737;
        tol_dist = 7;
        goal_x = 0;
        goal_y = 0;
        goal_hdg = 0;
        armed = 0;
        have_goal = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        push_item(1'b1, 32'd5, 32'd5, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
        push_item(1'b0, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'(25736));
        push_item(1'b1, 32'h80000000, 32'h7FFFFFFF, 16'(16384), 16'(-16384), 16'(16384),
            16'(-16384), 16'hFFFF);
        push_item(1'b1, 32'h7FFFFFFF, 32'h80000000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_item(1'b0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'(-25736));
        push_item(1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
        push_item(1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 16'(16384), 16'd0, 16'd0);
        push_item(1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 16'(-16384), 16'd0, 16'd0);
        push_item(1'b0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_item(1'b1, 32'd3, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
        push_item(1'b1, 32'd3, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
        push_item(1'b0, 32'h00010000, 32'h00010000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_item(1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
        push_item(1'b1, 32'd0, 32'd0, 16'(11585), 16'd0, 16'd0, 16'(11585), 16'd0);
        push_item(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0, 16'(16384), 16'd0, 16'd0,
            16'd0);
        wait_drained();

        // extremes of configuration
        cfg_write(wgc_pkg::REG_ANGLE_GAIN, 65535);
        cfg_write(wgc_pkg::REG_LINEAR_GAIN, 65535);
        cfg_write(wgc_pkg::REG_ANGLE_TOL, 0);
        cfg_write(wgc_pkg::REG_DIST_TOL, 65535);
        for (int i = 0; i < 12; i++)
            random_episode();
        wait_drained();

        cfg_write(wgc_pkg::REG_ANGLE_GAIN, 0);
        cfg_write(wgc_pkg::REG_LINEAR_GAIN, 0);
        cfg_write(wgc_pkg::REG_ANGLE_TOL, 25736);
        cfg_write(wgc_pkg::REG_DIST_TOL, 0);
        for (int i = 0; i < 12; i++)
            random_episode();
        wait_drained();

        cfg_write(wgc_pkg::REG_ANGLE_GAIN, 42598);
        cfg_write(wgc_pkg::REG_LINEAR_GAIN, 62259);
        cfg_write(wgc_pkg::REG_ANGLE_TOL, 737);
        cfg_write(wgc_pkg::REG_DIST_TOL, 7);

        // receiver holds off while the sender keeps offering
        for (int i = 0; i < 6; i++)
            random_episode();
        hold_cnt = 600;
        while (hold_cnt > 0)
            @(posedge clk);
        wait_drained();

        // sender pause until everything is back
        for (int i = 0; i < 4; i++)
            random_episode();
        repeat (150) @(posedge clk);
        sender_pause = 1;
        while (expected_q.size() > 0 || in_ch.valid)
            @(posedge clk);
        sender_pause = 0;
        wait_drained();

        while (feed_target < 560)
        begin
            cfg_write(wgc_pkg::REG_ANGLE_TOL, $urandom_range(0, 25736));
            cfg_write(wgc_pkg::REG_DIST_TOL, $urandom_range(0, 65535));
            cfg_write(wgc_pkg::REG_ANGLE_GAIN, $urandom_range(0, 65535));
            cfg_write(wgc_pkg::REG_LINEAR_GAIN, $urandom_range(0, 65535));
            for (int i = 0; i < 10; i++)
                random_episode();
            wait_drained();
        end

        quiet = 1;
        for (int i = 0; i < 15; i++)
            random_episode();
        wait_drained();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/wgc_pkg.sv
rtl/core/wgc_if.sv
rtl/core/wgc_ctrl.sv
rtl/core/wgc_dp.sv
rtl/core/waypoint_go_to_goal_controller.sv
tb/tb.sv
